>>> rtl/utf8s_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8s_pkg: shared types and constants of the UTF-8 control sanitizer
// Holds the byte and codepoint limits and the result group that travels
// from the front end through the queue to the serialiser.
// ----------------------------------------------------------------------------
package utf8s_pkg;

    // Replacement byte for anything that may not be shown.
    localparam logic [7:0] QMARK     = 8'h3F;
    localparam logic [7:0] ASCII_DEL = 8'h7F;
    localparam logic [7:0] CTRL_MAX  = 8'h1F;

    // Lead byte ranges.
    localparam logic [7:0] LEAD2_MIN = 8'hC2;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD4_MAX = 8'hF4;

    // Codepoint limits.
    localparam int unsigned CP_W = 21;
    localparam logic [CP_W-1:0] CP_MIN3     = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN4     = 21'h010000;
    localparam logic [CP_W-1:0] CP_SURR_LO  = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI  = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_C1_LO    = 21'h000080;
    localparam logic [CP_W-1:0] CP_C1_HI    = 21'h00009F;

    // Sequence lengths as held in the length register.
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    // Results caused by one input beat: one to four bytes.
    typedef struct packed {
        logic [3:0][7:0] bytes;   // bytes[0] goes out first
        logic [1:0]      cnt_m1;  // number of bytes minus one
        logic            last;    // the input beat closed the string
    } t_group;

endpackage

>>> rtl/utf8s_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8s_front: byte classifier and sequence tracker
// Accepts one byte per cycle while the queue is not full, tracks a pending
// multi-byte sequence and builds the byte's result group in the same cycle.
// ----------------------------------------------------------------------------
module utf8s_front
    import utf8s_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_wr,
    output t_group     o_group
);

    logic [1:0]      r_cnt, n_cnt;
    logic [2:0]      r_len, n_len;
    logic [CP_W-1:0] r_acc, n_acc;
    logic [7:0]      r_pend [3];
    logic [7:0]      n_pend [3];

    logic            w_accept;
    logic            w_is_cont;
    logic [2:0]      w_lead_len;
    logic [CP_W-1:0] w_acc_ext;
    logic            w_bad;
    logic            w_c1;
    logic [3:0][7:0] w_res;
    logic [2:0]      w_n_res;
    logic [7:0]      w_ascii;
    logic [7:0]      w_lead_bits;

    // Announced length of a lead byte, zero when it cannot start a sequence.
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        len = LEN_NONE;
        if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
            len = LEN_2;
        end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
            len = LEN_3;
        end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
            len = LEN_4;
        end
        return len;
    endfunction

    assign w_accept   = i_push && !i_full;
    assign w_is_cont  = (i_in_byte[7:6] == 2'b10);
    assign w_lead_len = lead_length(i_in_byte);
    assign w_acc_ext  = {r_acc[CP_W-7:0], i_in_byte[5:0]};

    // Control bytes and DEL are replaced, other ASCII passes.
    assign w_ascii = (i_in_byte <= CTRL_MAX || i_in_byte == ASCII_DEL) ? QMARK : i_in_byte;

    // Payload bits of a lead byte.
    always_comb begin
        unique case (w_lead_len)
            LEN_2:   w_lead_bits = i_in_byte & 8'h1F;
            LEN_3:   w_lead_bits = i_in_byte & 8'h0F;
            default: w_lead_bits = i_in_byte & 8'h07;
        endcase
    end

    // Checks on a completed codepoint.
    assign w_bad = (r_len == LEN_3 && w_acc_ext < CP_MIN3) ||
                   (r_len == LEN_4 && w_acc_ext < CP_MIN4) ||
                   (w_acc_ext >= CP_SURR_LO && w_acc_ext <= CP_SURR_HI) ||
                   (w_acc_ext > CP_MAX);
    assign w_c1  = (w_acc_ext >= CP_C1_LO) && (w_acc_ext <= CP_C1_HI);

    // Next state and the result group of this beat.
    always_comb begin
        n_cnt   = r_cnt;
        n_len   = r_len;
        n_acc   = r_acc;
        n_pend  = r_pend;
        w_res   = {4{QMARK}};
        w_n_res = 3'd0;
        if (r_cnt != 2'd0 && w_is_cont) begin
            if (({1'b0, r_cnt} + 3'd1) >= r_len) begin
                // Sequence complete.
                n_cnt = 2'd0;
                n_len = LEN_NONE;
                n_acc = '0;
                if (w_bad) begin
                    w_n_res = r_len;
                end else if (w_c1) begin
                    w_n_res = 3'd1;
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        if (k < int'(r_cnt)) begin
                            w_res[k] = r_pend[k];
                        end
                    end
                    w_res[r_cnt] = i_in_byte;
                    w_n_res      = {1'b0, r_cnt} + 3'd1;
                end
            end else begin
                // Sequence grows by one continuation byte.
                n_pend[r_cnt] = i_in_byte;
                n_cnt         = r_cnt + 2'd1;
                n_acc         = w_acc_ext;
            end
        end else begin
            // Held bytes, if any, are errors; the byte then starts afresh.
            n_cnt = 2'd0;
            n_len = LEN_NONE;
            n_acc = '0;
            if (!i_in_byte[7]) begin
                w_res[r_cnt] = w_ascii;
                w_n_res      = {1'b0, r_cnt} + 3'd1;
            end else if (w_lead_len != LEN_NONE) begin
                n_pend[0] = i_in_byte;
                n_cnt     = 2'd1;
                n_len     = w_lead_len;
                n_acc     = {{(CP_W-8){1'b0}}, w_lead_bits};
                w_n_res   = {1'b0, r_cnt};
            end else begin
                w_n_res = {1'b0, r_cnt} + 3'd1;
            end
        end
        // End of string flushes whatever is still held.
        if (i_in_last && n_cnt != 2'd0) begin
            w_n_res = w_n_res + {1'b0, n_cnt};
            n_cnt   = 2'd0;
            n_len   = LEN_NONE;
            n_acc   = '0;
        end
    end

    // Sequence state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_len <= LEN_NONE;
            r_acc <= '0;
        end else if (w_accept) begin
            r_cnt <= n_cnt;
            r_len <= n_len;
            r_acc <= n_acc;
        end
    end

    // Held bytes carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend <= n_pend;
        end
    end

    assign o_wr           = w_accept && (w_n_res != 3'd0);
    assign o_group.bytes  = w_res;
    assign o_group.cnt_m1 = w_n_res[1:0] - 2'd1;
    assign o_group.last   = i_in_last;

endmodule

>>> rtl/utf8s_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8s_fifo: result group queue
// Short register queue between the front end and the serialiser; the head
// entry is presented directly.
// ----------------------------------------------------------------------------
module utf8s_fifo
    import utf8s_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_group i_wdata,
    input  logic   i_rd,
    output t_group o_rdata,
    output logic   o_full,
    output logic   o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_group          r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, n_wptr;
    logic [AW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_count, n_count;

    // Pointer and fill count update.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_wr) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_rd) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rptr];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);

    // The front end never writes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("group written into full queue");

    // The serialiser never pops an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> !o_empty)
        else $error("group read from empty queue");

    // A lone write grows the fill count by exactly one.
    a_count_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr && !i_rd) |=> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("fill count did not follow a write");

    // The fill count stays within the depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count beyond depth");

endmodule

>>> rtl/utf8s_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8s_back: result serialiser
// Walks through the bytes of the head group, one beat per cycle while pop
// is high and the queue is not empty; it pops the group with its final byte.
// ----------------------------------------------------------------------------
module utf8s_back
    import utf8s_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_group     i_group,
    input  logic       i_empty,
    input  logic       i_pop,
    output logic [7:0] o_out_byte,
    output logic       o_run_end,
    output logic       o_text_end,
    output logic       o_rd
);

    logic [1:0] r_idx, n_idx;
    logic       w_fire;

    assign w_fire     = i_pop && !i_empty;
    assign o_out_byte = i_group.bytes[r_idx];
    assign o_run_end  = (r_idx == i_group.cnt_m1);
    assign o_text_end = o_run_end && i_group.last;
    assign o_rd       = w_fire && o_run_end;

    // Byte index within the head group.
    always_comb begin
        n_idx = r_idx;
        if (w_fire) begin
            n_idx = o_run_end ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else begin
            r_idx <= n_idx;
        end
    end

    // The index only moves on a delivered beat.
    a_idx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> $stable(r_idx))
        else $error("byte index moved without a beat");

    // A beat that is not the group's last steps to the next byte.
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !o_run_end) |=> (r_idx == 2'($past(r_idx) + 2'd1)))
        else $error("byte index did not advance");

    // A group release rewinds the byte index to the first byte.
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd |=> (r_idx == 2'd0))
        else $error("index not rewound after group release");

endmodule

>>> rtl/utf8_control_sanitizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_control_sanitizer: UTF-8 validating display-text sanitizer
// Front end classifies bytes, a group queue decouples it from a serialiser.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle whenever full is low and delivers one
// result beat per cycle whenever pop is high and empty is low; both sides
// run at that rate together. Each input byte is classified in the cycle it
// is accepted, and all results it causes (none to four bytes) are written as
// one group into a P_DEPTH-entry queue, so the first result can be taken in
// the next cycle. The serialiser delivers one byte of a group per beat, so a
// group of four bytes holds the queue head while later bytes keep queuing
// behind it. Held bytes and waiting result bytes together never exceed four,
// so with pop held high at most four entries are ever occupied, and the
// default depth of five keeps full low; full rises only when the result side
// stalls and the queue fills. Control bytes, DEL, malformed, overlong,
// surrogate and out-of-range sequences and C1 codepoints are replaced by '?'.
// ----------------------------------------------------------------------------
module utf8_control_sanitizer
    import utf8s_pkg::*;
#(
    parameter int P_DEPTH = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_run_end,
    output logic       o_text_end
);

    logic   w_wr;
    logic   w_rd;
    t_group w_wgroup;
    t_group w_head;

    // Classification and sequence tracking.
    utf8s_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_full    (full),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .o_wr      (w_wr),
        .o_group   (w_wgroup)
    );

    // Result group queue.
    utf8s_fifo #(
        .DEPTH (P_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_wdata (w_wgroup),
        .i_rd    (w_rd),
        .o_rdata (w_head),
        .o_full  (full),
        .o_empty (empty)
    );

    // Byte serialiser.
    utf8s_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_group    (w_head),
        .i_empty    (empty),
        .i_pop      (pop),
        .o_out_byte (o_out_byte),
        .o_run_end  (o_run_end),
        .o_text_end (o_text_end),
        .o_rd       (w_rd)
    );

endmodule
